// ===== design/first_fit_block_allocator_unit_defines.svh =====
// ----------------------------------------------------------------------------
// First-fit block allocator assertion macros
// Shared property forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_UNIT_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define FFBA_AST_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ffba port check failed");

// Next-cycle implication, checked out of reset
`define FFBA_AST_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ffba port check failed");

`endif

// ===== design/ffba_pkg.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator package
// Sizes, operation and status codes, and the structs shared by cells and control.
// ----------------------------------------------------------------------------
`default_nettype none

package ffba_pkg;

    localparam int MAX_BLOCKS   = 64;
    localparam int HEADER_BYTES = 12;
    localparam int IDX_W        = $clog2(MAX_BLOCKS);
    localparam int CNT_W        = $clog2(MAX_BLOCKS + 1);
    localparam int CFG_IDX_W    = 1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_END  = 1'd1;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NOSPACE  = 2'd1;
    localparam logic [1:0] ST_UNKNOWN  = 2'd2;
    localparam logic [1:0] ST_OVERFLOW = 2'd3;

    typedef enum logic [1:0] {
        FN_ALLOC   = 2'd0,
        FN_FREE    = 2'd1,
        FN_REALLOC = 2'd2,
        FN_CALLOC  = 2'd3
    } t_ffba_func;

    // Request fields broadcast to every cell during a scan
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] size;
    } t_ffba_req;

    // Running scan result passed from cell to cell
    typedef struct packed {
        logic             valid;
        logic             m_hit;
        logic             m_free;
        logic             m_big;
        logic [IDX_W-1:0] m_idx;
        logic             f_hit;
        logic [IDX_W-1:0] f_idx;
        logic [31:0]      f_addr;
    } t_ffba_tok;

    // Table update issued at the end of a scan
    typedef struct packed {
        logic             take_en;
        logic [IDX_W-1:0] take_idx;
        logic             rel_en;
        logic [IDX_W-1:0] rel_idx;
        logic             app_en;
        logic [IDX_W-1:0] app_idx;
        logic [31:0]      app_addr;
        logic [31:0]      app_size;
    } t_ffba_cmd;

endpackage

`default_nettype wire

// ===== design/ffba_cell.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator table cell
// Holds one block entry, folds its match and fit into the passing scan token.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_cell
    import ffba_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic [IDX_W-1:0] i_cell_idx,
    input  wire t_ffba_req        i_req,
    input  wire t_ffba_cmd        i_cmd,
    input  wire t_ffba_tok        i_tok,
    output t_ffba_tok             o_tok
);

    logic        r_valid;
    logic        r_free;
    logic [31:0] r_daddr;
    logic [31:0] r_size;
    t_ffba_tok   r_tok;
    t_ffba_tok   n_tok;

    logic w_hit;
    logic w_big;
    logic w_fit;

    // Compare this entry against the request
    assign w_hit = r_valid && (r_daddr == i_req.addr);
    assign w_big = (r_size >= i_req.size);
    assign w_fit = r_valid && r_free && w_big;

    // Keep the earliest match and the earliest fit seen so far
    always_comb begin
        n_tok = i_tok;
        if (!i_tok.m_hit && w_hit) begin
            n_tok.m_hit  = 1'b1;
            n_tok.m_idx  = i_cell_idx;
            n_tok.m_free = r_free;
            n_tok.m_big  = w_big;
        end
        if (!i_tok.f_hit && w_fit) begin
            n_tok.f_hit  = 1'b1;
            n_tok.f_idx  = i_cell_idx;
            n_tok.f_addr = r_daddr;
        end
    end

    // Advance the token and apply table updates addressed to this entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid     <= 1'b0;
            r_free      <= 1'b0;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
            if (i_cmd.app_en && (i_cmd.app_idx == i_cell_idx)) begin
                r_valid <= 1'b1;
                r_free  <= 1'b0;
                r_daddr <= i_cmd.app_addr;
                r_size  <= i_cmd.app_size;
            end
            if (i_cmd.take_en && (i_cmd.take_idx == i_cell_idx)) begin
                r_free <= 1'b0;
            end
            if (i_cmd.rel_en && (i_cmd.rel_idx == i_cell_idx)) begin
                r_free <= 1'b1;
            end
        end
    end

    assign o_tok = r_tok;

endmodule

`default_nettype wire

// ===== design/ffba_ctrl.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator control
// Sequences one request: size product, scan launch, decision and table update.
// ----------------------------------------------------------------------------
`default_nettype none

module ffba_ctrl
    import ffba_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_func,
    input  wire logic [31:0]          i_size_bytes,
    input  wire logic [31:0]          i_address,
    input  wire logic [31:0]          i_elem_count,
    input  wire logic [31:0]          i_elem_size,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data,
    output t_ffba_req                 o_req,
    output t_ffba_cmd                 o_cmd,
    output t_ffba_tok                 o_tok,
    input  wire t_ffba_tok            i_tok,
    output logic                      o_done,
    output logic [31:0]               o_result_address,
    output logic [1:0]                o_status,
    output logic                      o_reused
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SIZE,
        S_SCAN,
        S_WAIT
    } t_state;

    t_state     r_state;
    t_ffba_func r_func;
    logic [31:0] r_size;
    logic [31:0] r_addr;
    logic [31:0] r_ecnt;
    logic [31:0] r_esz;
    logic [63:0] r_prod;
    logic [31:0] r_req_size;
    logic        r_ovf;
    logic [33:0] r_top;
    logic [31:0] r_new_daddr;
    logic [CNT_W-1:0] r_count;
    logic [31:0] r_bp;
    logic [31:0] r_heap_base;
    logic [31:0] r_heap_end;
    logic        r_done;
    logic [31:0] r_res_addr;
    logic [1:0]  r_res_status;
    logic        r_res_reused;

    logic [63:0] w_prod;
    logic        w_accept;
    logic        w_decide;
    logic        w_room;
    logic        w_top_ok;

    // Outcome of a plain allocation with the scanned size
    logic [1:0]  a_status;
    logic [31:0] a_addr;
    logic        a_reuse;
    logic        a_take;
    logic        a_app;

    // Outcome of the whole request
    logic [1:0]  d_status;
    logic [31:0] d_addr;
    logic        d_reuse;
    logic        d_take;
    logic        d_app;
    logic        d_rel;

    assign w_accept = start && (r_state == S_IDLE);
    assign w_decide = (r_state == S_WAIT) && i_tok.valid;
    assign w_prod   = 64'(r_ecnt) * 64'(r_esz);
    assign w_room   = (r_count < CNT_W'(MAX_BLOCKS));
    assign w_top_ok = (r_top <= {2'b00, r_heap_end});

    // Broadcast request and launch the scan token into the first cell
    assign o_req.addr = r_addr;
    assign o_req.size = r_req_size;

    always_comb begin
        o_tok       = '0;
        o_tok.valid = (r_state == S_SCAN);
    end

    // Zero size fails; else first fit, else append at the break if room remains
    always_comb begin
        a_status = ST_OK;
        a_addr   = '0;
        a_reuse  = 1'b0;
        a_take   = 1'b0;
        a_app    = 1'b0;
        priority if (r_req_size == '0) begin
            a_status = ST_NOSPACE;
        end else if (i_tok.f_hit) begin
            a_addr  = i_tok.f_addr;
            a_reuse = 1'b1;
            a_take  = 1'b1;
        end else if (!w_room || !w_top_ok) begin
            a_status = ST_NOSPACE;
        end else begin
            a_addr = r_new_daddr;
            a_app  = 1'b1;
        end
    end

    // Resolve the request from the scan result
    always_comb begin
        d_status = a_status;
        d_addr   = a_addr;
        d_reuse  = a_reuse;
        d_take   = a_take;
        d_app    = a_app;
        d_rel    = 1'b0;
        unique case (r_func)
            FN_ALLOC: begin
            end
            FN_FREE: begin
                d_status = ST_OK;
                d_addr   = '0;
                d_reuse  = 1'b0;
                d_take   = 1'b0;
                d_app    = 1'b0;
                if (r_addr != '0) begin
                    if (i_tok.m_hit) begin
                        d_rel = 1'b1;
                    end else begin
                        d_status = ST_UNKNOWN;
                    end
                end
            end
            FN_REALLOC: begin
                if (r_addr != '0) begin
                    priority if (!i_tok.m_hit || i_tok.m_free) begin
                        d_status = ST_UNKNOWN;
                        d_addr   = '0;
                        d_reuse  = 1'b0;
                        d_take   = 1'b0;
                        d_app    = 1'b0;
                    end else if (i_tok.m_big) begin
                        d_status = ST_OK;
                        d_addr   = r_addr;
                        d_reuse  = 1'b0;
                        d_take   = 1'b0;
                        d_app    = 1'b0;
                    end else begin
                        d_rel = (a_status == ST_OK);
                    end
                end
            end
            FN_CALLOC: begin
                if (r_ovf) begin
                    d_status = ST_OVERFLOW;
                    d_addr   = '0;
                    d_reuse  = 1'b0;
                    d_take   = 1'b0;
                    d_app    = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // Table update, valid only in the deciding cycle
    always_comb begin
        o_cmd          = '0;
        o_cmd.take_en  = w_decide && d_take;
        o_cmd.take_idx = i_tok.f_idx;
        o_cmd.rel_en   = w_decide && d_rel;
        o_cmd.rel_idx  = i_tok.m_idx;
        o_cmd.app_en   = w_decide && d_app;
        o_cmd.app_idx  = r_count[IDX_W-1:0];
        o_cmd.app_addr = r_new_daddr;
        o_cmd.app_size = r_req_size;
    end

    // Sequencer, allocator registers and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_done      <= 1'b0;
            r_count     <= '0;
            r_bp        <= '0;
            r_heap_base <= '0;
            r_heap_end  <= '0;
        end else begin
            r_done <= w_decide;

            // The user must write registers only while idle; the block itself does not enforce it
            if (i_cfg_we) begin
                if (i_cfg_idx == REG_HEAP_BASE) begin
                    r_heap_base <= i_cfg_data;
                    if (r_count == '0) begin
                        r_bp <= i_cfg_data;
                    end
                end
                if (i_cfg_idx == REG_HEAP_END) begin
                    r_heap_end <= i_cfg_data;
                end
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_func  <= t_ffba_func'(i_func);
                        r_size  <= i_size_bytes;
                        r_addr  <= i_address;
                        r_ecnt  <= i_elem_count;
                        r_esz   <= i_elem_size;
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_SIZE;
                end
                S_SIZE: begin
                    if (r_func == FN_CALLOC) begin
                        r_req_size <= r_prod[31:0];
                        r_ovf      <= (r_prod[63:32] != '0);
                    end else begin
                        r_req_size <= r_size;
                        r_ovf      <= 1'b0;
                    end
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_top       <= {2'b00, r_bp} + 34'(HEADER_BYTES) + {2'b00, r_req_size};
                    r_new_daddr <= r_bp + 32'(HEADER_BYTES);
                    r_state     <= S_WAIT;
                end
                S_WAIT: begin
                    if (w_decide) begin
                        r_res_addr   <= d_addr;
                        r_res_status <= d_status;
                        r_res_reused <= d_reuse;
                        if (d_app) begin
                            r_count <= r_count + CNT_W'(1);
                            r_bp    <= r_top[31:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy             = (r_state != S_IDLE);
    assign o_done           = r_done;
    assign o_result_address = r_res_addr;
    assign o_status         = r_res_status;
    assign o_reused         = r_res_reused;

endmodule

`default_nettype wire

// ===== design/first_fit_block_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator unit
// Block table as a chain of cells scanned by a passing token, with control.
// ----------------------------------------------------------------------------
//  channel   | direction | handshake            | payload
//  request   | in        | start && !busy       | i_func, i_size_bytes, i_address,
//            |           |                      | i_elem_count, i_elem_size
//  result    | out       | o_done, one cycle    | o_result_address, o_status, o_reused
//  config    | in        | i_cfg_we             | i_cfg_idx, i_cfg_data
//
//  After the transfer the control forms the size product, selects the size and
//  launches the scan; the scan token then steps one cell per cycle through the
//  table. busy drops in the cycle the result strobe shows, so the next request
//  may transfer at the edge ending it. Reset is synchronous, active low; it
//  empties the table and clears both registers. The result cannot be stalled;
//  o_done is not held; the result outputs keep their values to the next result.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_block_allocator_unit
    import ffba_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 start,
    output logic                      busy,
    input  wire logic [1:0]           i_func,
    input  wire logic [31:0]          i_size_bytes,
    input  wire logic [31:0]          i_address,
    input  wire logic [31:0]          i_elem_count,
    input  wire logic [31:0]          i_elem_size,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]          i_cfg_data,
    output logic                      o_done,
    output logic [31:0]               o_result_address,
    output logic [1:0]                o_status,
    output logic                      o_reused
);

    t_ffba_req w_req;
    t_ffba_cmd w_cmd;
    t_ffba_tok w_tok [0:MAX_BLOCKS];

    // Request sequencing and table updates
    ffba_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_func           (i_func),
        .i_size_bytes     (i_size_bytes),
        .i_address        (i_address),
        .i_elem_count     (i_elem_count),
        .i_elem_size      (i_elem_size),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .o_req            (w_req),
        .o_cmd            (w_cmd),
        .o_tok            (w_tok[0]),
        .i_tok            (w_tok[MAX_BLOCKS]),
        .o_done           (o_done),
        .o_result_address (o_result_address),
        .o_status         (o_status),
        .o_reused         (o_reused)
    );

    // Table entries, earliest entry first in the token path
    for (genvar g = 0; g < MAX_BLOCKS; g++) begin : g_cell
        ffba_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_cell_idx (IDX_W'(g)),
            .i_req      (w_req),
            .i_cmd      (w_cmd),
            .i_tok      (w_tok[g]),
            .o_tok      (w_tok[g+1])
        );
    end

endmodule

`default_nettype wire

// ===== design/ffba_checker.sv =====
// ----------------------------------------------------------------------------
// First-fit block allocator port checker
// Watches the top-level ports for request and result ordering and result sanity.
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_fit_block_allocator_unit_defines.svh"

module ffba_checker
    import ffba_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 start,
    input wire logic                 busy,
    input wire logic                 o_done,
    input wire logic [31:0]          o_result_address,
    input wire logic [1:0]           o_status,
    input wire logic                 o_reused
);

    // A transfer starts work that holds busy and gives no result right away
    `FFBA_AST_NEXT(a_xfer_busy, i_clk, i_rst_n, start && !busy, busy && !o_done)

    // A result only follows a cycle of work
    `FFBA_AST_NOW(a_done_after_busy, i_clk, i_rst_n, o_done, $past(busy))

    // Failed requests hand out no address
    `FFBA_AST_NOW(a_fail_no_addr, i_clk, i_rst_n, o_done && o_status != ST_OK, ~|o_result_address)

    // Reuse of a free block is always a success
    `FFBA_AST_NOW(a_reuse_ok, i_clk, i_rst_n, o_done && o_reused, o_status == ST_OK)

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (.*);

`default_nettype wire
